>>> hdl/script_line_lexer_defines.svh
// ----------------------------------------------------------------------------
// script_line_lexer_defines: assertion macros
// Concurrent checks used by the lexer; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_LINE_LEXER_DEFINES_SVH
`define SCRIPT_LINE_LEXER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLL_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLL_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SLL_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons, msg)
`define SLL_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

>>> hdl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg: script line lexer types, constants and helpers
// Word types, token codes, character constants and the lexing functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sll_pkg;

    localparam int WORD_CHARS = 8;
    localparam int WB_IDX_W   = $clog2(WORD_CHARS);
    localparam int WORD_COUNT = 16;

    localparam logic [31:0] MANTISSA_MAX   = 32'hFFFF_FFFF;
    localparam logic [3:0]  FRAC_MAX       = 4'd9;
    localparam logic [1:0]  POINT_MAX      = 2'd2;
    localparam logic [15:0] LINE_COUNT_MAX = 16'hFFFF;

    // token kinds
    localparam logic [4:0] KIND_NUMBER     = 5'd0;
    localparam logic [4:0] KIND_KEYWORD    = 5'd1;
    localparam logic [4:0] KIND_DATATYPE   = 5'd2;
    localparam logic [4:0] KIND_BOOLEAN    = 5'd3;
    localparam logic [4:0] KIND_IDENT      = 5'd4;
    localparam logic [4:0] KIND_REL        = 5'd5;
    localparam logic [4:0] KIND_ASSIGN     = 5'd6;
    localparam logic [4:0] KIND_OP         = 5'd7;
    localparam logic [4:0] KIND_BRACE_OPEN = 5'd8;
    localparam logic [4:0] KIND_BRACE_CLOSE = 5'd9;
    localparam logic [4:0] KIND_PAREN_OPEN = 5'd10;
    localparam logic [4:0] KIND_PAREN_CLOSE = 5'd11;
    localparam logic [4:0] KIND_SQ_OPEN    = 5'd12;
    localparam logic [4:0] KIND_SQ_CLOSE   = 5'd13;
    localparam logic [4:0] KIND_COMMA      = 5'd14;
    localparam logic [4:0] KIND_LINE_END   = 5'd15;
    localparam logic [4:0] KIND_STRING     = 5'd16;

    // operator and relation subcodes
    localparam logic [2:0] SUB_NONE     = 3'd0;
    localparam logic [2:0] SUB_OP_PLUS  = 3'd0;
    localparam logic [2:0] SUB_OP_MINUS = 3'd1;
    localparam logic [2:0] SUB_OP_MUL   = 3'd2;
    localparam logic [2:0] SUB_OP_DIV   = 3'd3;
    localparam logic [2:0] SUB_OP_MOD   = 3'd4;
    localparam logic [2:0] SUB_REL_EQ   = 3'd0;
    localparam logic [2:0] SUB_REL_GE   = 3'd1;
    localparam logic [2:0] SUB_REL_GT   = 3'd2;
    localparam logic [2:0] SUB_REL_LE   = 3'd3;
    localparam logic [2:0] SUB_REL_LT   = 3'd4;

    // characters
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_POINT      = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_WORD,
        MODE_STR,
        MODE_EQ,
        MODE_GT,
        MODE_LT,
        MODE_MINUS
    } lex_mode_t;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } item_word_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [2:0]  subcode;
        logic [11:0] start_column;
        logic [12:0] text_length;
        logic [15:0] line_number;
        logic [31:0] mantissa;
        logic [3:0]  fraction_digits;
        logic        negative;
        logic        overflowed;
        logic        last;
    } token_word_t;

    typedef struct packed {
        logic [31:0] digit;
        logic [3:0]  frac;
        logic        sat;
    } num_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] kind;
        logic [2:0] sub;
    } tok_code_t;

    typedef struct packed {
        logic [63:0] text;   // right-justified ASCII
        logic [3:0]  len;
        logic [4:0]  kind;
        logic [2:0]  sub;
    } word_entry_t;

    typedef logic [WORD_CHARS-1:0][7:0] word_buf_t;

    localparam num_t NUM_ZERO = '{digit: 32'd0, frac: 4'd0, sat: 1'b0};

    localparam word_entry_t WORD_TABLE [WORD_COUNT] = '{
        '{"if",       4'd2, KIND_KEYWORD,  3'd0},
        '{"else",     4'd4, KIND_KEYWORD,  3'd1},
        '{"while",    4'd5, KIND_KEYWORD,  3'd2},
        '{"for",      4'd3, KIND_KEYWORD,  3'd3},
        '{"variable", 4'd8, KIND_KEYWORD,  3'd4},
        '{"Function", 4'd8, KIND_KEYWORD,  3'd5},
        '{"return",   4'd6, KIND_KEYWORD,  3'd6},
        '{"class",    4'd5, KIND_KEYWORD,  3'd7},
        '{"Integer",  4'd7, KIND_DATATYPE, 3'd0},
        '{"Boolean",  4'd7, KIND_DATATYPE, 3'd1},
        '{"String",   4'd6, KIND_DATATYPE, 3'd2},
        '{"Array",    4'd5, KIND_DATATYPE, 3'd3},
        '{"Floating", 4'd8, KIND_DATATYPE, 3'd4},
        '{"File",     4'd4, KIND_DATATYPE, 3'd5},
        '{"False",    4'd5, KIND_BOOLEAN,  3'd0},
        '{"True",     4'd4, KIND_BOOLEAN,  3'd1}
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
    endfunction

    // mode entered by a character that starts a token
    function automatic lex_mode_t fresh_mode(input logic [7:0] c);
        lex_mode_t m;
        m = MODE_IDLE;
        if (is_digit(c))
            m = MODE_NUM;
        else if (is_alpha(c))
            m = MODE_WORD;
        else if (c == CH_EQUAL)
            m = MODE_EQ;
        else if (c == CH_GREATER)
            m = MODE_GT;
        else if (c == CH_LESS)
            m = MODE_LT;
        else if (c == CH_MINUS)
            m = MODE_MINUS;
        else if (c == CH_QUOTE)
            m = MODE_STR;
        return m;
    endfunction

    // single-character tokens emitted at once
    function automatic tok_code_t fresh_token(input logic [7:0] c);
        tok_code_t r;
        r = '{hit: 1'b1, kind: KIND_OP, sub: SUB_NONE};
        case (c)
            CH_PLUS:     r.sub = SUB_OP_PLUS;
            CH_STAR:     r.sub = SUB_OP_MUL;
            CH_SLASH:    r.sub = SUB_OP_DIV;
            CH_PERCENT:  r.sub = SUB_OP_MOD;
            CH_LBRACE:   r.kind = KIND_BRACE_OPEN;
            CH_RBRACE:   r.kind = KIND_BRACE_CLOSE;
            CH_LPAREN:   r.kind = KIND_PAREN_OPEN;
            CH_RPAREN:   r.kind = KIND_PAREN_CLOSE;
            CH_LBRACKET: r.kind = KIND_SQ_OPEN;
            CH_RBRACKET: r.kind = KIND_SQ_CLOSE;
            CH_COMMA:    r.kind = KIND_COMMA;
            CH_SEMI:     r.kind = KIND_LINE_END;
            default:     r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // mantissa times ten plus digit, saturating; fraction digits capped
    function automatic num_t add_digit(input num_t cur, input logic point_seen,
                                       input logic [7:0] c);
        num_t        r;
        logic [35:0] t;
        r = cur;
        t = ({4'd0, cur.digit} << 3) + ({4'd0, cur.digit} << 1) + {32'd0, c[3:0]};
        if (!(point_seen && (cur.frac >= FRAC_MAX)))
        begin
            if (point_seen)
                r.frac = cur.frac + 4'd1;
            if (t[35:32] != 4'd0)
            begin
                r.digit = MANTISSA_MAX;
                r.sat   = 1'b1;
            end
            else
                r.digit = t[31:0];
        end
        return r;
    endfunction

    // len is 0 for words longer than the buffer
    function automatic tok_code_t match_word(input word_buf_t wbuf, input logic [3:0] len);
        tok_code_t   r;
        logic [63:0] w;
        r = '{hit: 1'b0, kind: KIND_IDENT, sub: SUB_NONE};
        w = '0;
        for (int k = 0; k < WORD_CHARS; k++)
            if (4'(k) < len)
                w = {w[55:0], wbuf[k]};
        for (int i = 0; i < WORD_COUNT; i++)
            if (!r.hit && (len == WORD_TABLE[i].len) && (w == WORD_TABLE[i].text))
                r = '{hit: 1'b1, kind: WORD_TABLE[i].kind, sub: WORD_TABLE[i].sub};
        return r;
    endfunction

    function automatic token_word_t make_token(input logic [4:0] kind, input logic [2:0] sub,
                                               input logic [11:0] start,
                                               input logic [12:0] len,
                                               input logic [15:0] line);
        token_word_t r;
        r = '0;
        r.kind         = kind;
        r.subcode      = sub;
        r.start_column = start;
        r.text_length  = len;
        r.line_number  = line;
        return r;
    endfunction

    // token closed by the pending mode
    function automatic token_word_t flush_result(input lex_mode_t mode,
                                                 input logic [11:0] start,
                                                 input logic [12:0] len,
                                                 input logic [15:0] line,
                                                 input num_t num, input logic minus,
                                                 input word_buf_t wbuf,
                                                 input logic [3:0] wlen);
        token_word_t r;
        tok_code_t   w;
        w = match_word(wbuf, wlen);
        r = make_token(KIND_OP, SUB_OP_MINUS, start, 13'd1, line);
        case (mode)
            MODE_NUM:
            begin
                r.kind            = KIND_NUMBER;
                r.subcode         = SUB_NONE;
                r.text_length     = len;
                r.mantissa        = num.digit;
                r.fraction_digits = num.frac;
                r.negative        = minus;
                r.overflowed      = num.sat;
            end
            MODE_WORD:
            begin
                r.kind        = w.kind;
                r.subcode     = w.sub;
                r.text_length = len;
            end
            MODE_STR:
            begin
                r.kind        = KIND_STRING;
                r.subcode     = SUB_NONE;
                r.text_length = len;
            end
            MODE_EQ:
            begin
                r.kind    = KIND_ASSIGN;
                r.subcode = SUB_NONE;
            end
            MODE_GT:
            begin
                r.kind    = KIND_REL;
                r.subcode = SUB_REL_GT;
            end
            MODE_LT:
            begin
                r.kind    = KIND_REL;
                r.subcode = SUB_REL_LT;
            end
            default: ;  // lone minus keeps the operator set above
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/script_line_lexer.sv
// ----------------------------------------------------------------------------
// script_line_lexer: streaming lexer, one character or end-of-line per word
// Tokens: a token word enters the token queue when the input word that ends it is accepted.
// Throughput: one input word per cycle while the 4-deep token queue holds <= 2 words;
//   an input causing two tokens queues both, and tok_word hands them out one at a time.
// Reset: asynchronous; lexer idle, line 1, column 0, queue empty; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "script_line_lexer_defines.svh"

module script_line_lexer
    import sll_pkg::*;
#(
    parameter int LINE_MAX = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        src_valid,
    output logic             src_ready,
    input  wire item_word_t  src_word,
    output logic             tok_valid,
    input  wire logic        tok_ready,
    output token_word_t      tok_word
);

    // column and length counters hold LINE_MAX itself; positions stop one short
    localparam int LEN_W = $clog2(LINE_MAX + 1);
    localparam int POS_W = $clog2(LINE_MAX);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(LINE_MAX - 1);

    // output queue: up to two tokens per input word
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Lexer state
    // ------------------------------------------------------------------
    lex_mode_t          lex_mode_reg,       lex_mode_next;
    logic [LEN_W-1:0]   column_count_reg,   column_count_next;
    logic [POS_W-1:0]   token_start_reg,    token_start_next;
    logic [LEN_W-1:0]   token_length_reg,   token_length_next;
    logic [15:0]        line_count_reg,     line_count_next;
    num_t               num_reg,            num_next;
    logic [1:0]         point_count_reg,    point_count_next;
    logic               minus_seen_reg,     minus_seen_next;
    word_buf_t          word_buf_reg,       word_buf_next;
    logic               line_has_token_reg, line_has_token_next;
    logic [4:0]         last_kind_reg,      last_kind_next;

    // token queue, entry 0 drives the output
    token_word_t        q_reg [QUEUE_DEPTH];
    token_word_t        q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0]  q_count_reg, q_count_next;

    logic               accept;
    logic               pop;
    logic [QCNT_W-1:0]  q_fill;
    logic [7:0]         ch;
    logic [POS_W-1:0]   pos;
    logic [3:0]         word_len;
    tok_code_t          fresh;
    token_word_t        res_a, res_b;
    logic [1:0]         res_count;

    // ------------------------------------------------------------------
    // Handshake. Ready is registered only: room for two more words.
    // ------------------------------------------------------------------
    assign src_ready = (q_count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign accept    = src_valid && src_ready;
    assign tok_valid = (q_count_reg != '0);
    assign tok_word  = q_reg[0];
    assign pop       = tok_valid && tok_ready;

    assign ch    = src_word.char_code;
    assign fresh = fresh_token(ch);
    assign pos   = (column_count_reg < LEN_LIMIT) ? POS_W'(column_count_reg) : POS_LAST;
    // only words up to the buffer size can hit the keyword table
    assign word_len = (token_length_reg <= LEN_W'(WORD_CHARS)) ? 4'(token_length_reg) : 4'd0;

    // ------------------------------------------------------------------
    // Mode next state
    // ------------------------------------------------------------------
    always_comb
    begin
        lex_mode_next = lex_mode_reg;
        if (accept)
        begin
            if (src_word.action)
                lex_mode_next = MODE_IDLE;
            else
            begin
                case (lex_mode_reg)
                    MODE_NUM:
                        if (is_digit(ch))
                            lex_mode_next = MODE_NUM;
                        else if (ch == CH_POINT)
                            // second point closes the number
                            lex_mode_next = (point_count_reg != 2'd0) ? MODE_IDLE : MODE_NUM;
                        else
                            lex_mode_next = fresh_mode(ch);
                    MODE_WORD:
                        lex_mode_next = is_word_char(ch) ? MODE_WORD : fresh_mode(ch);
                    MODE_STR:
                        lex_mode_next = (ch == CH_QUOTE) ? MODE_IDLE : MODE_STR;
                    MODE_EQ, MODE_GT, MODE_LT:
                        lex_mode_next = (ch == CH_EQUAL) ? MODE_IDLE : fresh_mode(ch);
                    MODE_MINUS:
                        lex_mode_next = is_digit(ch) ? MODE_NUM : fresh_mode(ch);
                    default:
                        lex_mode_next = fresh_mode(ch);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Token datapath: flush / relation first, then a fresh single-char token
    // ------------------------------------------------------------------
    always_comb
    begin : lex_datapath
        logic        used;
        logic        flush_now;
        logic        rel_now;
        logic [2:0]  rel_sub;
        logic        has_tok;
        logic [4:0]  tail_kind;
        token_word_t t;

        token_length_next   = token_length_reg;
        token_start_next    = token_start_reg;
        column_count_next   = column_count_reg;
        line_count_next     = line_count_reg;
        num_next            = num_reg;
        point_count_next    = point_count_reg;
        minus_seen_next     = minus_seen_reg;
        word_buf_next       = word_buf_reg;
        line_has_token_next = line_has_token_reg;
        last_kind_next      = last_kind_reg;
        used      = 1'b0;
        flush_now = 1'b0;
        rel_now   = 1'b0;
        rel_sub   = SUB_REL_EQ;
        has_tok   = line_has_token_reg;
        tail_kind = last_kind_reg;
        t         = '0;
        res_a     = '0;
        res_b     = '0;
        res_count = 2'd0;

        if (accept)
        begin
            if (src_word.action)
                flush_now = 1'b1;
            else
            begin
                case (lex_mode_reg)
                    MODE_NUM:
                        if (is_digit(ch))
                        begin
                            if (token_length_reg < LEN_LIMIT)
                                token_length_next = token_length_reg + LEN_W'(1);
                            num_next = add_digit(num_reg, point_count_reg != 2'd0, ch);
                            used     = 1'b1;
                        end
                        else if (ch == CH_POINT)
                        begin
                            if (token_length_reg < LEN_LIMIT)
                                token_length_next = token_length_reg + LEN_W'(1);
                            used = 1'b1;
                            if (point_count_reg != POINT_MAX)
                                point_count_next = point_count_reg + 2'd1;
                            if (point_count_next == POINT_MAX)
                                flush_now = 1'b1;
                        end
                        else
                            flush_now = 1'b1;
                    MODE_WORD:
                        if (is_word_char(ch))
                        begin
                            if (token_length_reg < LEN_W'(WORD_CHARS))
                                word_buf_next[token_length_reg[WB_IDX_W-1:0]] = ch;
                            if (token_length_reg < LEN_LIMIT)
                                token_length_next = token_length_reg + LEN_W'(1);
                            used = 1'b1;
                        end
                        else
                            flush_now = 1'b1;
                    MODE_STR:
                    begin
                        used = 1'b1;
                        if (ch == CH_QUOTE)
                            flush_now = 1'b1;
                        else if (token_length_reg < LEN_LIMIT)
                            token_length_next = token_length_reg + LEN_W'(1);
                    end
                    MODE_EQ:
                        if (ch == CH_EQUAL)
                        begin
                            used    = 1'b1;
                            rel_now = 1'b1;
                            rel_sub = SUB_REL_EQ;
                        end
                        else
                            flush_now = 1'b1;
                    MODE_GT:
                        if (ch == CH_EQUAL)
                        begin
                            used    = 1'b1;
                            rel_now = 1'b1;
                            rel_sub = SUB_REL_GE;
                        end
                        else
                            flush_now = 1'b1;
                    MODE_LT:
                        if (ch == CH_EQUAL)
                        begin
                            used    = 1'b1;
                            rel_now = 1'b1;
                            rel_sub = SUB_REL_LE;
                        end
                        else
                            flush_now = 1'b1;
                    MODE_MINUS:
                        if (is_digit(ch))
                        begin
                            // minus sign joins the number
                            used              = 1'b1;
                            minus_seen_next   = 1'b1;
                            token_length_next = LEN_W'(2);
                            point_count_next  = 2'd0;
                            num_next          = add_digit(NUM_ZERO, 1'b0, ch);
                        end
                        else
                            flush_now = 1'b1;
                    default: ;
                endcase
            end

            if (flush_now && (lex_mode_reg != MODE_IDLE))
            begin
                res_a = flush_result(lex_mode_reg, 12'(token_start_reg),
                                     13'(token_length_next), line_count_reg, num_reg,
                                     minus_seen_reg, word_buf_reg, word_len);
                res_count = 2'd1;
            end
            else if (rel_now)
            begin
                res_a = make_token(KIND_REL, rel_sub, 12'(token_start_reg), 13'd2,
                                   line_count_reg);
                res_count = 2'd1;
            end

            if (src_word.action)
            begin
                if (res_count != 2'd0)
                begin
                    has_tok   = 1'b1;
                    tail_kind = res_a.kind;
                end
                // implicit line end unless the line closed itself
                if (has_tok && (tail_kind != KIND_LINE_END) && (tail_kind != KIND_BRACE_OPEN))
                begin
                    t = make_token(KIND_LINE_END, SUB_NONE,
                                   12'((column_count_reg == '0) ? '0 :
                                       POS_W'(column_count_reg - LEN_W'(1))),
                                   13'd1, line_count_reg);
                    if (res_count == 2'd0)
                        res_a = t;
                    else
                        res_b = t;
                    res_count = res_count + 2'd1;
                end
                if (line_count_reg != LINE_COUNT_MAX)
                    line_count_next = line_count_reg + 16'd1;
                column_count_next   = '0;
                line_has_token_next = 1'b0;
                last_kind_next      = KIND_NUMBER;
            end
            else
            begin
                if (!used)
                begin
                    token_start_next = pos;
                    if (is_digit(ch))
                    begin
                        minus_seen_next   = 1'b0;
                        token_length_next = LEN_W'(1);
                        point_count_next  = 2'd0;
                        num_next          = add_digit(NUM_ZERO, 1'b0, ch);
                    end
                    else if (is_alpha(ch))
                    begin
                        token_length_next = LEN_W'(1);
                        word_buf_next[0]  = ch;
                    end
                    else if (ch == CH_QUOTE)
                        token_length_next = '0;

                    if (fresh.hit)
                    begin
                        t = make_token(fresh.kind, fresh.sub, 12'(pos), 13'd1,
                                       line_count_reg);
                        if (res_count == 2'd0)
                            res_a = t;
                        else
                            res_b = t;
                        res_count = res_count + 2'd1;
                    end
                end
                if (column_count_reg < LEN_LIMIT)
                    column_count_next = column_count_reg + LEN_W'(1);
                if (res_count == 2'd2)
                begin
                    line_has_token_next = 1'b1;
                    last_kind_next      = res_b.kind;
                end
                else if (res_count == 2'd1)
                begin
                    line_has_token_next = 1'b1;
                    last_kind_next      = res_a.kind;
                end
            end

            if (res_count == 2'd1)
                res_a.last = 1'b1;
            else if (res_count == 2'd2)
                res_b.last = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Token queue: shift out at the head, append behind what stays
    // ------------------------------------------------------------------
    always_comb
    begin
        q_fill = q_count_reg - QCNT_W'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_next[i] = q_reg[i];
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            if (pop)
                q_next[i] = q_reg[i + 1];
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if ((QCNT_W'(i) == q_fill) && (res_count != 2'd0))
                q_next[i] = res_a;
            if ((QCNT_W'(i) == QCNT_W'(q_fill + QCNT_W'(1))) && (res_count == 2'd2))
                q_next[i] = res_b;
        end
        q_count_next = q_fill + QCNT_W'(res_count);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode_reg       <= MODE_IDLE;
            column_count_reg   <= '0;
            token_start_reg    <= '0;
            token_length_reg   <= '0;
            line_count_reg     <= 16'd1;
            num_reg            <= NUM_ZERO;
            point_count_reg    <= 2'd0;
            minus_seen_reg     <= 1'b0;
            word_buf_reg       <= '0;
            line_has_token_reg <= 1'b0;
            last_kind_reg      <= KIND_NUMBER;
            q_count_reg        <= '0;
        end
        else
        begin
            lex_mode_reg       <= lex_mode_next;
            column_count_reg   <= column_count_next;
            token_start_reg    <= token_start_next;
            token_length_reg   <= token_length_next;
            line_count_reg     <= line_count_next;
            num_reg            <= num_next;
            point_count_reg    <= point_count_next;
            minus_seen_reg     <= minus_seen_next;
            word_buf_reg       <= word_buf_next;
            line_has_token_reg <= line_has_token_next;
            last_kind_reg      <= last_kind_next;
            q_count_reg        <= q_count_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SLL_ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, q_count_reg <= QCNT_W'(QUEUE_DEPTH), "token queue overrun")
    `SLL_ASSERT_IMPLY(a_pair_last, clk, rst_n, res_count == 2'd2, !res_a.last && res_b.last, "last flag misplaced on token pair")
    `SLL_ASSERT_IMPLY(a_non_number_clean, clk, rst_n, tok_valid && (tok_word.kind != KIND_NUMBER), (tok_word.mantissa == 32'd0) && (tok_word.fraction_digits == 4'd0) && !tok_word.negative && !tok_word.overflowed, "number fields set on non-number token")
    `SLL_ASSERT_NEXT(a_eol_resets_line, clk, rst_n, accept && src_word.action, (column_count_reg == '0) && (lex_mode_reg == MODE_IDLE) && !line_has_token_reg, "line state not cleared after end of line")

endmodule

`default_nettype wire

>>> sim/tb_script_line_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_script_line_lexer: self-checking bench for the streaming line lexer
// Feeds character and end-of-line words, predicts every token word in a
// scoreboard of its own and checks each one as it leaves the block.
// ----------------------------------------------------------------------------

module tb_script_line_lexer
    import sll_pkg::*;
();

    class token_tracker;
        localparam int LINE_LIMIT  = 4096;
        localparam int KEY_CHARS   = WORD_CHARS;
        localparam int FIRST_TYPE  = 8;
        localparam int FIRST_BOOL  = 14;
        localparam int MAX_REPORTS = 10;

        token_word_t expected_tokens[$];
        token_word_t step_out[$];
        int          error_count;
        int          checked_count;

        // lexer state as the block should hold it
        lex_mode_t   mode;
        int unsigned column;
        int unsigned tok_start;
        int unsigned tok_len;
        int unsigned line_no;
        logic [31:0] mant;
        int unsigned frac;
        int unsigned points;
        bit          minus;
        bit          sat;
        bit          has_token;
        logic [4:0]  last_kind;
        logic [7:0]  spell[KEY_CHARS];

        function new();
            mode      = MODE_IDLE;
            column    = 0;
            tok_start = 0;
            tok_len   = 0;
            line_no   = 1;
            mant      = '0;
            frac      = 0;
            points    = 0;
            minus     = 1'b0;
            sat       = 1'b0;
            has_token = 1'b0;
            last_kind = '0;
            foreach (spell[i])
                spell[i] = '0;
            error_count   = 0;
            checked_count = 0;
        endfunction

        // spelling of the fixed word list: keywords, then datatypes, then booleans
        static function string vocab_word(input int idx);
            case (idx)
                0:       return "if";
                1:       return "else";
                2:       return "while";
                3:       return "for";
                4:       return "variable";
                5:       return "Function";
                6:       return "return";
                7:       return "class";
                8:       return "Integer";
                9:       return "Boolean";
                10:      return "String";
                11:      return "Array";
                12:      return "Floating";
                13:      return "File";
                14:      return "False";
                default: return "True";
            endcase
        endfunction

        function bit is_numeral(input logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_letter(input logic [7:0] c);
            return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                   (c >= CH_LOWER_A && c <= CH_LOWER_Z);
        endfunction

        function bit is_blank(input logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // at most two tokens per word; a third would be dropped
        function void put_token(input logic [4:0] kind, input logic [2:0] sub,
                                input int unsigned start, input int unsigned len,
                                input bit num);
            token_word_t t;
            if (step_out.size() >= 2)
                return;
            t              = '0;
            t.kind         = kind;
            t.subcode      = sub;
            t.start_column = start[11:0];
            t.text_length  = len[12:0];
            t.line_number  = line_no[15:0];
            if (num)
            begin
                t.mantissa        = mant;
                t.fraction_digits = frac[3:0];
                t.negative        = minus;
                t.overflowed      = sat;
            end
            step_out.insert(step_out.size(), t);
            last_kind = kind;
            has_token = 1'b1;
        endfunction

        function void bump_length();
            if (tok_len < LINE_LIMIT)
                tok_len++;
        endfunction

        function void push_digit(input logic [7:0] c);
            longint unsigned t;
            if (points != 0)
            begin
                if (frac >= FRAC_MAX)
                    return;
                frac++;
            end
            t = 64'(mant) * 64'd10 + 64'(c - CH_ZERO);
            if (t > 64'(MANTISSA_MAX))
            begin
                mant = MANTISSA_MAX;
                sat  = 1'b1;
            end
            else
                mant = t[31:0];
        endfunction

        function void open_number(input logic [7:0] c, input int unsigned len);
            mode    = MODE_NUM;
            tok_len = len;
            mant    = '0;
            frac    = 0;
            points  = 0;
            sat     = 1'b0;
            push_digit(c);
        endfunction

        function void close_word();
            string      w;
            bit         found;
            int         idx;
            logic [4:0] kind;
            logic [2:0] sub;
            found = 1'b0;
            idx   = 0;
            if (tok_len <= KEY_CHARS)
            begin
                for (int i = 0; i < 16 && !found; i++)
                begin
                    w = vocab_word(i);
                    if (w.len() == tok_len)
                    begin
                        found = 1'b1;
                        for (int k = 0; k < w.len(); k++)
                            if (w[k] != spell[k])
                                found = 1'b0;
                        if (found)
                            idx = i;
                    end
                end
            end
            if (!found)
            begin
                kind = KIND_IDENT;
                sub  = SUB_NONE;
            end
            else if (idx < FIRST_TYPE)
            begin
                kind = KIND_KEYWORD;
                sub  = 3'(idx);
            end
            else if (idx < FIRST_BOOL)
            begin
                kind = KIND_DATATYPE;
                sub  = 3'(idx - FIRST_TYPE);
            end
            else
            begin
                kind = KIND_BOOLEAN;
                sub  = 3'(idx - FIRST_BOOL);
            end
            put_token(kind, sub, tok_start, tok_len, 1'b0);
        endfunction

        function void close_pending();
            case (mode)
                MODE_NUM:   put_token(KIND_NUMBER, SUB_NONE, tok_start, tok_len, 1'b1);
                MODE_WORD:  close_word();
                MODE_STR:   put_token(KIND_STRING, SUB_NONE, tok_start, tok_len, 1'b0);
                MODE_EQ:    put_token(KIND_ASSIGN, SUB_NONE, tok_start, 1, 1'b0);
                MODE_GT:    put_token(KIND_REL, SUB_REL_GT, tok_start, 1, 1'b0);
                MODE_LT:    put_token(KIND_REL, SUB_REL_LT, tok_start, 1, 1'b0);
                MODE_MINUS: put_token(KIND_OP, SUB_OP_MINUS, tok_start, 1, 1'b0);
                default: ;
            endcase
            mode = MODE_IDLE;
        endfunction

        // character seen with nothing pending
        function void open_token(input logic [7:0] c, input int unsigned pos);
            tok_start = pos;
            if (is_blank(c))
                return;
            if (is_numeral(c))
            begin
                minus = 1'b0;
                open_number(c, 1);
                return;
            end
            if (is_letter(c))
            begin
                mode     = MODE_WORD;
                tok_len  = 1;
                spell[0] = c;
                return;
            end
            case (c)
                CH_EQUAL:    mode = MODE_EQ;
                CH_GREATER:  mode = MODE_GT;
                CH_LESS:     mode = MODE_LT;
                CH_MINUS:    mode = MODE_MINUS;
                CH_QUOTE:
                begin
                    mode    = MODE_STR;
                    tok_len = 0;
                end
                CH_PLUS:     put_token(KIND_OP, SUB_OP_PLUS, pos, 1, 1'b0);
                CH_STAR:     put_token(KIND_OP, SUB_OP_MUL, pos, 1, 1'b0);
                CH_SLASH:    put_token(KIND_OP, SUB_OP_DIV, pos, 1, 1'b0);
                CH_PERCENT:  put_token(KIND_OP, SUB_OP_MOD, pos, 1, 1'b0);
                CH_LBRACE:   put_token(KIND_BRACE_OPEN, SUB_NONE, pos, 1, 1'b0);
                CH_RBRACE:   put_token(KIND_BRACE_CLOSE, SUB_NONE, pos, 1, 1'b0);
                CH_LPAREN:   put_token(KIND_PAREN_OPEN, SUB_NONE, pos, 1, 1'b0);
                CH_RPAREN:   put_token(KIND_PAREN_CLOSE, SUB_NONE, pos, 1, 1'b0);
                CH_LBRACKET: put_token(KIND_SQ_OPEN, SUB_NONE, pos, 1, 1'b0);
                CH_RBRACKET: put_token(KIND_SQ_CLOSE, SUB_NONE, pos, 1, 1'b0);
                CH_COMMA:    put_token(KIND_COMMA, SUB_NONE, pos, 1, 1'b0);
                CH_SEMI:     put_token(KIND_LINE_END, SUB_NONE, pos, 1, 1'b0);
                default: ;
            endcase
        endfunction

        // one accepted input word: advance the state, queue the tokens it causes
        function void absorb_item(input item_word_t w);
            int unsigned pos;
            int unsigned endcol;
            bit          used;
            logic [7:0]  c;
            step_out.delete();
            if (w.action)
            begin
                close_pending();
                if (has_token && last_kind != KIND_LINE_END && last_kind != KIND_BRACE_OPEN)
                begin
                    endcol = (column > 0) ? column - 1 : 0;
                    if (endcol > LINE_LIMIT - 1)
                        endcol = LINE_LIMIT - 1;
                    put_token(KIND_LINE_END, SUB_NONE, endcol, 1, 1'b0);
                end
                if (line_no < LINE_COUNT_MAX)
                    line_no++;
                column    = 0;
                has_token = 1'b0;
                last_kind = '0;
            end
            else
            begin
                c    = w.char_code;
                pos  = (column < LINE_LIMIT) ? column : LINE_LIMIT - 1;
                used = 1'b0;
                case (mode)
                    MODE_NUM:
                        if (is_numeral(c))
                        begin
                            bump_length();
                            push_digit(c);
                            used = 1'b1;
                        end
                        else if (c == CH_POINT)
                        begin
                            bump_length();
                            used = 1'b1;
                            if (points < 2)
                                points++;
                            if (points >= 2)
                                close_pending();
                        end
                        else
                            close_pending();
                    MODE_WORD:
                        if (is_letter(c) || is_numeral(c) || c == CH_UNDERSCORE)
                        begin
                            if (tok_len < KEY_CHARS)
                                spell[tok_len] = c;
                            bump_length();
                            used = 1'b1;
                        end
                        else
                            close_pending();
                    MODE_STR:
                    begin
                        used = 1'b1;
                        if (c == CH_QUOTE)
                            close_pending();
                        else
                            bump_length();
                    end
                    MODE_EQ:
                        if (c == CH_EQUAL)
                        begin
                            mode = MODE_IDLE;
                            used = 1'b1;
                            put_token(KIND_REL, SUB_REL_EQ, tok_start, 2, 1'b0);
                        end
                        else
                            close_pending();
                    MODE_GT, MODE_LT:
                        if (c == CH_EQUAL)
                        begin
                            put_token(KIND_REL, (mode == MODE_GT) ? SUB_REL_GE : SUB_REL_LE,
                                      tok_start, 2, 1'b0);
                            mode = MODE_IDLE;
                            used = 1'b1;
                        end
                        else
                            close_pending();
                    MODE_MINUS:
                        if (is_numeral(c))
                        begin
                            minus = 1'b1;
                            open_number(c, 2);
                            used = 1'b1;
                        end
                        else
                            close_pending();
                    default:
                        mode = MODE_IDLE;
                endcase
                if (!used)
                    open_token(c, pos);
                if (column < LINE_LIMIT)
                    column++;
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                expected_tokens.insert(expected_tokens.size(), step_out[i]);
        endfunction

        function string describe(input token_word_t t);
            return $sformatf("kind %0d sub %0d col %0d len %0d line %0d mant %0d frac %0d %s",
                             t.kind, t.subcode, t.start_column, t.text_length, t.line_number,
                             t.mantissa, t.fraction_digits,
                             $sformatf("neg %0b ovf %0b last %0b",
                                       t.negative, t.overflowed, t.last));
        endfunction

        function void check_token(input token_word_t got);
            token_word_t want;
            checked_count++;
            if (expected_tokens.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected token: %s", describe(got));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.subcode !== want.subcode ||
                got.start_column !== want.start_column ||
                got.text_length !== want.text_length ||
                got.line_number !== want.line_number || got.mantissa !== want.mantissa ||
                got.fraction_digits !== want.fraction_digits ||
                got.negative !== want.negative ||
                got.overflowed !== want.overflowed || got.last !== want.last)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("token %0d mismatch", checked_count);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    localparam int CLK_PERIOD   = 10;
    localparam int LINE_LIMIT   = 4096;
    localparam int RANDOM_WORDS = 380;
    localparam int LONG_HOLD    = 400;      // receiver hold-off, fills the token queue
    localparam int HOLD_AFTER   = 80;       // tokens checked before the hold-off
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int SIGN_COUNT   = 19;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        src_valid = 1'b0;
    item_word_t  src_word  = '0;
    logic        src_ready;
    logic        tok_valid;
    logic        tok_ready = 1'b0;
    token_word_t tok_word;

    token_tracker board;
    bit           idle_on     = 1'b1;   // random gaps on both sides when set
    int           words_sent  = 0;
    int           cycle_count = 0;

    script_line_lexer #(
        .LINE_MAX(LINE_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_word  (src_word),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_word  (tok_word)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // relations, operators, brackets and separators as source text
    function automatic string sign_text(input int idx);
        case (idx)
            0:       return "==";
            1:       return ">=";
            2:       return "<=";
            3:       return ">";
            4:       return "<";
            5:       return "=";
            6:       return "+";
            7:       return "-";
            8:       return "*";
            9:       return "/";
            10:      return "%";
            11:      return "{";
            12:      return "}";
            13:      return "(";
            14:      return ")";
            15:      return "[";
            16:      return "]";
            17:      return ",";
            default: return ";";
        endcase
    endfunction

    // Offer one input word and hold it until the block takes it. The gap
    // before it is drawn afresh for every word; valid stays up across
    // back-to-back words so it is never dropped and raised in one step.
    task automatic send_word(input item_word_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        do
            @(posedge clk);
        while (!src_ready);
        board.absorb_item(w);
        words_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_word(item_word_t'{action: 1'b0, char_code: c});
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // char_code is a don't-care here, so it is randomised
    task automatic end_line();
        send_word(item_word_t'{action: 1'b1, char_code: 8'($urandom_range(0, 255))});
    endtask

    task automatic send_random_lexeme();
        string      s;
        int         n;
        int         k;
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                // listed word, sometimes one character too long or too short
                s = token_tracker::vocab_word($urandom_range(0, WORD_COUNT - 1));
                k = $urandom_range(0, 3);
                if (k == 1)
                    s = s.substr(0, s.len() - 2);
                send_text(s);
                if (k == 0)
                    send_char(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            2, 3:
            begin
                if ($urandom_range(0, 1) != 0)
                    b = 8'(CH_LOWER_A + $urandom_range(0, 25));
                else
                    b = 8'(CH_UPPER_A + $urandom_range(0, 25));
                send_char(b);
                repeat ($urandom_range(0, 11))
                begin
                    case ($urandom_range(0, 3))
                        0:       b = 8'(CH_LOWER_A + $urandom_range(0, 25));
                        1:       b = 8'(CH_UPPER_A + $urandom_range(0, 25));
                        2:       b = 8'(CH_ZERO + $urandom_range(0, 9));
                        default: b = CH_UNDERSCORE;
                    endcase
                    send_char(b);
                end
            end
            4, 5:
            begin
                // mostly short numbers; now and then long enough to saturate
                if ($urandom_range(0, 3) == 0)
                    send_char(CH_MINUS);
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
                repeat (n)
                    send_char(8'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 2) == 0)
                begin
                    send_char(CH_POINT);
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12)
                                                    : $urandom_range(0, 3);
                    repeat (n)
                        send_char(8'(CH_ZERO + $urandom_range(0, 9)));
                    if ($urandom_range(0, 7) == 0)
                        send_char(CH_POINT);
                end
            end
            6:
            begin
                // quoted text, left open now and then
                send_char(CH_QUOTE);
                repeat ($urandom_range(0, 10))
                begin
                    if ($urandom_range(0, 9) == 0)
                        b = CH_TAB;
                    else
                    begin
                        b = 8'($urandom_range(CH_SPACE, 8'h7E));
                        if (b == CH_QUOTE)
                            b = CH_SPACE;
                    end
                    send_char(b);
                end
                if ($urandom_range(0, 5) != 0)
                    send_char(CH_QUOTE);
            end
            7, 8:
                send_text(sign_text($urandom_range(0, SIGN_COUNT - 1)));
            default:
                send_char(8'($urandom_range(0, 255)));
        endcase
    endtask

    // a line of random lexemes; gaps are switched per line so that some
    // lines run at full rate
    task automatic send_random_line();
        int k;
        idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 19) != 0)
        begin
            repeat ($urandom_range(1, 8))
            begin
                send_random_lexeme();
                k = $urandom_range(0, 9);
                if (k < 5)
                    send_char(CH_SPACE);
                else if (k == 5)
                    send_char(8'($urandom_range(CH_TAB, CH_CR)));
            end
            k = $urandom_range(0, 9);
            if (k < 3)
                send_char(CH_SEMI);
            else if (k < 5)
                send_char(CH_LBRACE);
        end
        end_line();
    endtask

    // token sink: random ready gaps, plus one long hold-off once enough
    // tokens have gone by, so the block backs up and stalls its input
    initial
    begin : token_sink
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && board.checked_count >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                gap       = LONG_HOLD;
            end
            else
                gap = idle_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                tok_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tok_ready <= 1'b1;
            do
                @(posedge clk);
            while (!tok_valid);
            board.check_token(tok_word);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int random_start;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines
        send_text("x=-12.5;");                      // assign then negative number
        end_line();
        send_text("a==b>=c<=d>e<f=g");              // every relation
        end_line();
        send_text("1.2.3 -y - 7");                  // second point, lone minus
        end_line();
        send_text("99999999999 0.12345678901 4294967295");   // saturation, fraction cap
        end_line();
        send_text("\"hi\tthere\" \"open");          // string with tab, left open
        end_line();
        send_text("Function{");                     // brace closes line: no line end
        end_line();
        end_line();                                 // empty line
        send_text("+*/%(){}[],");
        end_line();
        send_char(8'h00);                           // unknown bytes end tokens silently
        send_text("ab");
        send_char(8'hFF);
        send_text("9");
        send_char(8'h80);
        send_char(CH_TAB);
        send_text("=");                             // lookahead flushed at end of line
        end_line();
        send_text("abcdefghij variablex Floating File True False _");
        end_line();

        // random lines
        random_start = words_sent;
        while (words_sent < random_start + RANDOM_WORDS)
            send_random_line();

        src_valid <= 1'b0;
        while (board.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
